// ===== rtl/pfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcb_pkg
// Types, register indexes and channel helpers for the masked pixel format
// converter with alpha blend.
// ----------------------------------------------------------------------------
package pfcb_pkg;

  localparam int unsigned NUM_REGS = 8;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  chan_t;
  typedef logic [2:0]  reg_idx_t;

  localparam reg_idx_t REG_SRC_RED   = 3'd0;
  localparam reg_idx_t REG_SRC_GREEN = 3'd1;
  localparam reg_idx_t REG_SRC_BLUE  = 3'd2;
  localparam reg_idx_t REG_SRC_ALPHA = 3'd3;
  localparam reg_idx_t REG_DST_RED   = 3'd4;
  localparam reg_idx_t REG_DST_GREEN = 3'd5;
  localparam reg_idx_t REG_DST_BLUE  = 3'd6;
  localparam reg_idx_t REG_DST_ALPHA = 3'd7;

  localparam logic [NUM_REGS-1:0][31:0] MASK_RESET = {
    32'h0000_0000, 32'h0000_001F, 32'h0000_07E0, 32'h0000_F800,
    32'hFF00_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000
  };

  localparam chan_t ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic       zero;
    logic [4:0] shift;
    logic [3:0] loss;
  } geo_t;

  typedef struct packed {
    word_t src_pixel;
    word_t dst_pixel;
    logic  blend_mode;
  } in_t;

  typedef struct packed {
    word_t out_pixel;
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
  } out_t;

  function automatic chan_t unpack_chan(word_t px, word_t m, geo_t g);
    word_t t;
    t = (px & m) >> g.shift;
    return chan_t'(t[7:0] << g.loss);
  endfunction

  function automatic word_t pack_chan(chan_t c, geo_t g);
    word_t w;
    w = {24'd0, c >> g.loss};
    return w << g.shift;
  endfunction

endpackage

// ===== rtl/pfcb_geom.sv =====
// ----------------------------------------------------------------------------
// pfcb_geom
// Registered shift and loss of one channel mask: trailing zero count and
// 8 minus the length of the first run of ones, saturating at 0.
// ----------------------------------------------------------------------------
module pfcb_geom (
  input  logic           clk,
  input  pfcb_pkg::word_t mask,
  output pfcb_pkg::geo_t  geo
);
  import pfcb_pkg::*;

  word_t      fill;
  logic [5:0] tz;
  logic [5:0] ones;
  logic [5:0] run;
  geo_t       geo_nxt;
  geo_t       geo_r;

  assign fill = mask | (mask - 32'd1);

  always_comb begin
    tz   = 6'd0;
    ones = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) begin
        tz = 6'(i);
      end
      if (!fill[i]) begin
        ones = 6'(i);
      end
    end
  end

  assign run = ones - tz;

  always_comb begin
    geo_nxt.zero = (mask == '0);
    if (mask == '0) begin
      geo_nxt.shift = 5'd0;
      geo_nxt.loss  = 4'd8;
    end else begin
      geo_nxt.shift = tz[4:0];
      geo_nxt.loss  = (run >= 6'd8) ? 4'd0 : 4'(6'd8 - run);
    end
  end

  always_ff @(posedge clk) begin
    geo_r <= geo_nxt;
  end

  assign geo = geo_r;

endmodule

// ===== rtl/masked_pixel_format_convert_blend.sv =====
// Pipeline: a transaction accepted on start is registered in s1_r, s2_r, s3_r,
// s4_r and out_r in turn, and then shows its result on out_data with out_valid.
// Throughput: one transaction per cycle; busy stays low and results are never held.
// Reset: rst_n (synchronous, active low) empties the pipeline and loads the
// default masks (source ARGB8888, destination RGB565).
// ----------------------------------------------------------------------------
// masked_pixel_format_convert_blend
// Four-stage pipeline: unpack, blend multiply, blend add, repack.
// ----------------------------------------------------------------------------
module masked_pixel_format_convert_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pfcb_pkg::in_t      in_data,
  output logic               out_valid,
  output pfcb_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pfcb_pkg::reg_idx_t cfg_index,
  input  pfcb_pkg::word_t    cfg_data
);
  import pfcb_pkg::*;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
    chan_t dr;
    chan_t dg;
    chan_t db;
    word_t keep;
    logic  blend;
  } s2_t;

  typedef struct packed {
    logic signed [17:0] pr;
    logic signed [17:0] pg;
    logic signed [17:0] pb;
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
    chan_t dr;
    chan_t dg;
    chan_t db;
    word_t keep;
    logic  blend;
  } s3_t;

  typedef struct packed {
    chan_t pr;
    chan_t pg;
    chan_t pb;
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
    word_t keep;
    logic  blend;
  } s4_t;

  logic [NUM_REGS-1:0][31:0] mask_r;
  geo_t [NUM_REGS-1:0]       geo;

  logic accept;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  in_t  s1_r;
  s2_t  s2_nxt, s2_r;
  s3_t  s3_nxt, s3_r;
  s4_t  s4_nxt, s4_r;
  out_t out_nxt, out_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask_r[cfg_index] <= cfg_data;
    end
  end

  for (genvar i = 0; i < NUM_REGS; i++) begin : g_geom
    pfcb_geom u_geom (
      .clk  (clk),
      .mask (mask_r[i]),
      .geo  (geo[i])
    );
  end

  // unpack source and destination channels
  always_comb begin
    s2_nxt.r  = unpack_chan(s1_r.src_pixel, mask_r[REG_SRC_RED],   geo[REG_SRC_RED]);
    s2_nxt.g  = unpack_chan(s1_r.src_pixel, mask_r[REG_SRC_GREEN], geo[REG_SRC_GREEN]);
    s2_nxt.b  = unpack_chan(s1_r.src_pixel, mask_r[REG_SRC_BLUE],  geo[REG_SRC_BLUE]);
    s2_nxt.a  = geo[REG_SRC_ALPHA].zero ? ALPHA_OPAQUE :
                unpack_chan(s1_r.src_pixel, mask_r[REG_SRC_ALPHA], geo[REG_SRC_ALPHA]);
    s2_nxt.dr = unpack_chan(s1_r.dst_pixel, mask_r[REG_DST_RED],   geo[REG_DST_RED]);
    s2_nxt.dg = unpack_chan(s1_r.dst_pixel, mask_r[REG_DST_GREEN], geo[REG_DST_GREEN]);
    s2_nxt.db = unpack_chan(s1_r.dst_pixel, mask_r[REG_DST_BLUE],  geo[REG_DST_BLUE]);
    s2_nxt.keep  = s1_r.dst_pixel & mask_r[REG_DST_ALPHA];
    s2_nxt.blend = s1_r.blend_mode;
  end

  // blend multiply: (s - d) * alpha
  always_comb begin
    logic signed [8:0] ea;
    ea = $signed({1'b0, s2_r.a});
    s3_nxt.pr = ($signed({1'b0, s2_r.r}) - $signed({1'b0, s2_r.dr})) * ea;
    s3_nxt.pg = ($signed({1'b0, s2_r.g}) - $signed({1'b0, s2_r.dg})) * ea;
    s3_nxt.pb = ($signed({1'b0, s2_r.b}) - $signed({1'b0, s2_r.db})) * ea;
    s3_nxt.r     = s2_r.r;
    s3_nxt.g     = s2_r.g;
    s3_nxt.b     = s2_r.b;
    s3_nxt.a     = s2_r.a;
    s3_nxt.dr    = s2_r.dr;
    s3_nxt.dg    = s2_r.dg;
    s3_nxt.db    = s2_r.db;
    s3_nxt.keep  = s2_r.keep;
    s3_nxt.blend = s2_r.blend;
  end

  // blend add, select channels to repack
  always_comb begin
    logic signed [17:0] qr, qg, qb;
    qr = $signed(s3_r.pr) >>> 8;
    qg = $signed(s3_r.pg) >>> 8;
    qb = $signed(s3_r.pb) >>> 8;
    s4_nxt.r     = s3_r.r;
    s4_nxt.g     = s3_r.g;
    s4_nxt.b     = s3_r.b;
    s4_nxt.a     = s3_r.a;
    s4_nxt.keep  = s3_r.keep;
    s4_nxt.blend = s3_r.blend;
    if (s3_r.blend) begin
      s4_nxt.pr = s3_r.dr + qr[7:0];
      s4_nxt.pg = s3_r.dg + qg[7:0];
      s4_nxt.pb = s3_r.db + qb[7:0];
    end else begin
      s4_nxt.pr = s3_r.r;
      s4_nxt.pg = s3_r.g;
      s4_nxt.pb = s3_r.b;
    end
  end

  // repack into destination format
  always_comb begin
    out_nxt.out_pixel = pack_chan(s4_r.pr, geo[REG_DST_RED]) |
                        pack_chan(s4_r.pg, geo[REG_DST_GREEN]) |
                        pack_chan(s4_r.pb, geo[REG_DST_BLUE]) |
                        (s4_r.blend ? s4_r.keep : pack_chan(s4_r.a, geo[REG_DST_ALPHA]));
    out_nxt.src_red   = s4_r.r;
    out_nxt.src_green = s4_r.g;
    out_nxt.src_blue  = s4_r.b;
    out_nxt.src_alpha = s4_r.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= accept;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (s1_vld_r) begin
      s2_r <= s2_nxt;
    end
    if (s2_vld_r) begin
      s3_r <= s3_nxt;
    end
    if (s3_vld_r) begin
      s4_r <= s4_nxt;
    end
    if (s4_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted transaction did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> $past(s1_vld_r))
    else $error("stage valid without upstream transaction");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> mask_r[$past(cfg_index)] == $past(cfg_data))
    else $error("mask register write lost");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Pixel format converter and blender testbench
// Drives source and destination pixels in copy and blend mode through several
// mask formats (default, opaque source, zero, wide, split and top-bit masks,
// then random formats). Every result is checked field by field against an
// independent model of the unpack, blend and repack arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import pfcb_pkg::*;

  localparam logic MODE_COPY  = 1'b0;
  localparam logic MODE_BLEND = 1'b1;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   RANDOM_FORMATS = 10;
  localparam int   ITEMS_PER_FORMAT = 125;

  localparam word_t DEFAULT_MASKS [NUM_REGS] = '{
    32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
    32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000
  };

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_t      in_data;
  logic     out_valid;
  out_t     out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  reg_idx_t cfg_index;
  word_t    cfg_data;

  word_t    format_masks [NUM_REGS];
  out_t     pending_pixels [$];
  out_t     pixel_due;
  int       errors = 0;

  masked_pixel_format_convert_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Shift is the trailing zero count, loss is 8 minus the first run of ones.
  function automatic void mask_span(input word_t m, output int sh, output int ls);
    int run;
    sh  = 0;
    run = 0;
    if (m == '0) begin
      ls = 8;
      return;
    end
    while (!m[sh]) sh++;
    while (sh + run < 32 && m[sh + run]) run++;
    ls = (run >= 8) ? 0 : 8 - run;
  endfunction

  function automatic chan_t extract_channel(input word_t px, input word_t m);
    int    sh;
    int    ls;
    word_t t;
    mask_span(m, sh, ls);
    t = (px & m) >> sh;
    t = t << ls;
    return t[7:0];
  endfunction

  function automatic word_t place_channel(input chan_t c, input word_t m);
    int    sh;
    int    ls;
    word_t w;
    mask_span(m, sh, ls);
    w = {24'd0, c};
    w = w >> ls;
    return w << sh;
  endfunction

  function automatic chan_t mix_channel(input chan_t s, input chan_t d, input chan_t a);
    int    prod;
    int    sum;
    chan_t r;
    prod = (int'(s) - int'(d)) * int'(a);
    sum  = int'(d) + (prod >>> 8);
    r    = sum[7:0];
    return r;
  endfunction

  function automatic out_t convert_pixel(input in_t px);
    out_t  res;
    chan_t nr;
    chan_t ng;
    chan_t nb;
    res.src_red   = extract_channel(px.src_pixel, format_masks[REG_SRC_RED]);
    res.src_green = extract_channel(px.src_pixel, format_masks[REG_SRC_GREEN]);
    res.src_blue  = extract_channel(px.src_pixel, format_masks[REG_SRC_BLUE]);
    res.src_alpha = (format_masks[REG_SRC_ALPHA] == '0) ? 8'hFF :
                    extract_channel(px.src_pixel, format_masks[REG_SRC_ALPHA]);
    if (px.blend_mode == MODE_COPY) begin
      res.out_pixel = place_channel(res.src_red,   format_masks[REG_DST_RED])
                    | place_channel(res.src_green, format_masks[REG_DST_GREEN])
                    | place_channel(res.src_blue,  format_masks[REG_DST_BLUE])
                    | place_channel(res.src_alpha, format_masks[REG_DST_ALPHA]);
    end else begin
      nr = mix_channel(res.src_red,
             extract_channel(px.dst_pixel, format_masks[REG_DST_RED]), res.src_alpha);
      ng = mix_channel(res.src_green,
             extract_channel(px.dst_pixel, format_masks[REG_DST_GREEN]), res.src_alpha);
      nb = mix_channel(res.src_blue,
             extract_channel(px.dst_pixel, format_masks[REG_DST_BLUE]), res.src_alpha);
      res.out_pixel = place_channel(nr, format_masks[REG_DST_RED])
                    | place_channel(ng, format_masks[REG_DST_GREEN])
                    | place_channel(nb, format_masks[REG_DST_BLUE])
                    | (px.dst_pixel & format_masks[REG_DST_ALPHA]);
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input word_t exp, input word_t act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        pixel_due = pending_pixels.pop_front();
        compare_field("out_pixel", pixel_due.out_pixel, out_data.out_pixel);
        compare_field("src_red",   pixel_due.src_red,   out_data.src_red);
        compare_field("src_green", pixel_due.src_green, out_data.src_green);
        compare_field("src_blue",  pixel_due.src_blue,  out_data.src_blue);
        compare_field("src_alpha", pixel_due.src_alpha, out_data.src_alpha);
      end
    end
  end

  task automatic send_pixel(input word_t src, input word_t dst, input logic mode);
    in_t px;
    px.src_pixel  = src;
    px.dst_pixel  = dst;
    px.blend_mode = mode;
    @(negedge clk);
    start   = 1'b1;
    in_data = px;
    do @(posedge clk); while (busy !== 1'b0);
    pending_pixels.push_back(convert_pixel(px));
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Hold the sender until every outstanding transaction has returned.
  task automatic wait_drained();
    hold_off(1);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_mask(input reg_idx_t idx, input word_t value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    format_masks[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_format(input word_t sr, input word_t sg, input word_t sb,
                             input word_t sa, input word_t dr, input word_t dg,
                             input word_t db, input word_t da);
    wait_drained();
    write_mask(REG_SRC_RED,   sr);
    write_mask(REG_SRC_GREEN, sg);
    write_mask(REG_SRC_BLUE,  sb);
    write_mask(REG_SRC_ALPHA, sa);
    write_mask(REG_DST_RED,   dr);
    write_mask(REG_DST_GREEN, dg);
    write_mask(REG_DST_BLUE,  db);
    write_mask(REG_DST_ALPHA, da);
  endtask

  function automatic word_t random_mask();
    int          w;
    int          sh;
    logic [63:0] ones;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: begin
        w    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        sh   = $urandom_range(0, 32 - w);
        ones = ((64'd1 << w) - 64'd1) << sh;
        return ones[31:0];
      end
    endcase
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_default_format();
    send_pixel(32'h0000_0000, 32'h0000_0000, MODE_COPY);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_COPY);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, MODE_BLEND);
    send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF, MODE_BLEND);
    send_pixel(32'h8000_0000, 32'h0000_FFFF, MODE_BLEND);
    send_pixel(32'hFF12_3456, 32'hA5A5_A5A5, MODE_BLEND);
    send_pixel(32'h7F00_FF00, 32'h0000_5A5A, MODE_BLEND);
  endtask

  task automatic test_opaque_source();
    load_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h0000_0000,
                32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000);
    send_pixel(32'h0012_3456, 32'hFFFF_FFFF, MODE_COPY);
    send_pixel(32'h00AB_CDEF, 32'h5501_0203, MODE_BLEND);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, MODE_BLEND);
  endtask

  task automatic test_odd_masks();
    load_format(32'h000F_FF00, 32'h0F0F_0000, 32'h0000_0000, 32'h8000_0000,
                32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0F00, 32'hFF00_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_COPY);
    send_pixel(32'h8ABC_DE00, 32'h1234_5678, MODE_COPY);
    send_pixel(32'h8ABC_DE00, 32'h1234_5678, MODE_BLEND);
    send_pixel(32'h7FFF_FFFF, 32'hFFFF_FFFF, MODE_BLEND);
    load_format(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hC000_0000,
                32'h0000_0003, 32'h8000_0000, 32'h00FF_FF00, 32'hC000_0000);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, MODE_COPY);
    send_pixel(32'h4000_0001, 32'hFFFF_FFFF, MODE_BLEND);
    send_pixel(32'hC123_4567, 32'h89AB_CDEF, MODE_BLEND);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, MODE_BLEND);
  endtask

  task automatic test_random_formats();
    int sent;
    int burst;
    for (int f = 0; f < RANDOM_FORMATS; f++) begin
      load_format(random_mask(), random_mask(), random_mask(), random_mask(),
                  random_mask(), random_mask(), random_mask(), random_mask());
      sent = 0;
      while (sent < ITEMS_PER_FORMAT) begin
        burst = $urandom_range(1, 40);
        for (int i = 0; i < burst && sent < ITEMS_PER_FORMAT; i++) begin
          send_pixel(random_word(), random_word(), 1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SRC_RED;
    cfg_data  = '0;
    foreach (format_masks[i]) format_masks[i] = DEFAULT_MASKS[i];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_format();
    test_opaque_source();
    test_odd_masks();
    test_random_formats();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
